FILE: rtl/core/frs_pkg.sv
// Package for the fitness remainder selector: sizes, item types, cell and FSM types.
`default_nettype none

package frs_pkg;

  // Population and fitness sizing
  localparam int POP_SIZE     = 32;
  localparam int FITNESS_BITS = 32;

  // Port field widths, fixed by the item formats
  localparam int IN_FIT_W = 32;
  localparam int SRC_W    = 5;
  localparam int EXP_W    = 22;

  // Derived internal widths
  localparam int CNT_W  = $clog2(POP_SIZE + 1);
  localparam int IDX_W  = $clog2(POP_SIZE);
  localparam int SUM_W  = FITNESS_BITS + IDX_W;
  localparam int PROD_W = FITNESS_BITS + CNT_W;
  localparam int FRAC_W = 16;
  localparam int QUO_W  = EXP_W + 1;
  localparam int NUM_W  = PROD_W + FRAC_W;
  localparam int QCNT_W = $clog2(QUO_W + 1);

  typedef struct packed {
    logic [IN_FIT_W-1:0] fitness;
    logic                last_item;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_index;
    logic [EXP_W-1:0] expectation_q16;
    logic             is_copy;
    logic             last_result;
  } out_item_t;

  // One entry of the sorting chain
  typedef struct packed {
    logic [FITNESS_BITS-1:0] fit;
    logic [IDX_W-1:0]        idx;
  } entry_t;

  // Command broadcast to every chain cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_ORIG,
    ST_COPY
  } sel_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/frs_cell.sv
// One cell of the systolic sorting chain: holds one entry, passes the loser right.
`default_nettype none

module frs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frs_pkg::cell_cmd_t cmd_i,
  input  logic              left_vld_i,
  input  frs_pkg::entry_t   left_i,
  input  logic              right_vld_i,
  input  frs_pkg::entry_t   right_i,
  output logic              held_vld_o,
  output frs_pkg::entry_t   held_o,
  output logic              carry_vld_o,
  output frs_pkg::entry_t   carry_o
);
  import frs_pkg::*;

  logic   held_vld_q, held_vld_d;
  entry_t held_q, held_d;
  logic   carry_vld_q, carry_vld_d;
  entry_t carry_q, carry_d;

  // Insert: higher fitness, or equal fitness at a lower index, displaces the held entry
  always_comb begin
    held_vld_d  = held_vld_q;
    held_d      = held_q;
    carry_vld_d = 1'b0;
    carry_d     = left_i;
    if (cmd_i.clear) begin
      held_vld_d = 1'b0;
    end else if (cmd_i.shift) begin
      held_vld_d = right_vld_i;
      held_d     = right_i;
    end else if (left_vld_i) begin
      if (!held_vld_q) begin
        held_vld_d = 1'b1;
        held_d     = left_i;
      end else if ((left_i.fit > held_q.fit) ||
                   ((left_i.fit == held_q.fit) && (left_i.idx < held_q.idx))) begin
        held_d      = left_i;
        carry_vld_d = 1'b1;
        carry_d     = held_q;
      end else begin
        carry_vld_d = 1'b1;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q  <= 1'b0;
      carry_vld_q <= 1'b0;
    end else begin
      held_vld_q  <= held_vld_d;
      carry_vld_q <= carry_vld_d;
    end
  end

  // Entry payloads
  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    carry_q <= carry_d;
  end

  assign held_vld_o  = held_vld_q;
  assign held_o      = held_q;
  assign carry_vld_o = carry_vld_q;
  assign carry_o     = carry_q;

endmodule

`default_nettype wire

FILE: rtl/core/frs_div.sv
// Serial restoring divider: saturated Q16 expectation, one quotient bit per cycle.
`default_nettype none

module frs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [frs_pkg::PROD_W-1:0]  num_i,
  input  logic [frs_pkg::SUM_W-1:0]   den_i,
  output logic                        done_o,
  output logic [frs_pkg::EXP_W-1:0]   quo_o
);
  import frs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  num_q, num_d;
  logic [QUO_W-1:0]  quo_q, quo_d;

  logic [NUM_W-1:0]  num_full;
  logic [SUM_W:0]    trial;
  logic              fits;

  // Numerator scaled by 2^16; its top bits are always below the divisor
  assign num_full = {num_i, {FRAC_W{1'b0}}};
  assign trial    = {rem_q, num_q[QUO_W-1]};
  assign fits     = trial >= {1'b0, den_i};

  // Load on start, finishing without steps for a zero divisor, then one subtract-and-shift per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      quo_d = '0;
      rem_d = SUM_W'(num_full[NUM_W-1:QUO_W]);
      num_d = num_full[QUO_W-1:0];
      cnt_d = QCNT_W'(QUO_W);
      if (den_i == '0) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? SUM_W'(trial - {1'b0, den_i}) : trial[SUM_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      num_d = {num_q[QUO_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == QCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  // Saturate at the largest 22-bit value
  assign done_o = done_q;
  assign quo_o  = quo_q[QUO_W-1] ? {EXP_W{1'b1}} : quo_q[EXP_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/fitness_remainder_selector_top.sv
// Top level of the fitness remainder selector: load, sort chain, expectation and emit.
// Loading takes one item per cycle while in the load state; each fitness, up to POP_SIZE
// of them, enters a chain of POP_SIZE sorting cells, which settles in a drain state before emission.
// Each emitted original passes through multiply, divider load, the divider steps (skipped when
// the sum is zero), divider done and emit; a copy, where due, follows its original out.
// An output stall holds the emit and copy states.
// Reset clears the chain valid bits, sum, count, divider and FSM; payloads are not reset.
`default_nettype none

module fitness_remainder_selector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  frs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output frs_pkg::out_item_t out_item_o
);
  import frs_pkg::*;

  sel_state_e state_q, state_d;

  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  drain_q;
  logic [CNT_W-1:0]  emit_cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic              copy_ok_q;
  logic              out_valid_q;
  out_item_t         out_item_q, out_d;

  logic      accept, ins_vld, finish, out_load, slot_free, last_res, div_start, div_done;
  logic [EXP_W-1:0] div_quo;
  entry_t    ins;
  cell_cmd_t cmd;

  // Chain links: link[k] feeds cell k from the left, held[k+1] feeds it from the right
  logic [POP_SIZE:0] link_vld;
  entry_t            link [POP_SIZE+1];
  logic [POP_SIZE:0] held_vld;
  entry_t            held [POP_SIZE+1];

  assign accept    = in_valid_i && (state_q == ST_LOAD);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_res  = (CNT_W'(emit_cnt_q + 1'b1) == count_q);

  assign ins.fit = FITNESS_BITS'(in_item_i.fitness);
  assign ins.idx = count_q[IDX_W-1:0];

  assign link_vld[0]        = ins_vld;
  assign link[0]            = ins;
  assign held_vld[POP_SIZE] = 1'b0;
  assign held[POP_SIZE]     = '0;

  // Sorting chain
  for (genvar k = 0; k < POP_SIZE; k++) begin : g_cell
    frs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_vld_i  (link_vld[k]),
      .left_i      (link[k]),
      .right_vld_i (held_vld[k+1]),
      .right_i     (held[k+1]),
      .held_vld_o  (held_vld[k]),
      .held_o      (held[k]),
      .carry_vld_o (link_vld[k+1]),
      .carry_o     (link[k+1])
    );
  end

  // Expectation of the head entry
  frs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state and control
  always_comb begin
    state_d   = state_q;
    cmd       = '0;
    ins_vld   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    finish    = 1'b0;
    out_d.source_index    = SRC_W'(held[0].idx);
    out_d.expectation_q16 = div_quo;
    out_d.is_copy         = 1'b0;
    out_d.last_result     = last_res;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          ins_vld = count_q < CNT_W'(POP_SIZE);
          if (in_item_i.last_item) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_q == CNT_W'(POP_SIZE - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_d = ST_ORIG;
        end
      end
      ST_ORIG: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (last_res) begin
            finish    = 1'b1;
            cmd.clear = 1'b1;
            state_d   = ST_LOAD;
          end else if (copy_ok_q) begin
            state_d = ST_COPY;
          end else begin
            cmd.shift = 1'b1;
            state_d   = ST_MUL;
          end
        end
      end
      ST_COPY: begin
        out_d.is_copy = 1'b1;
        if (slot_free) begin
          out_load = 1'b1;
          if (last_res) begin
            finish    = 1'b1;
            cmd.clear = 1'b1;
            state_d   = ST_LOAD;
          end else begin
            cmd.shift = 1'b1;
            state_d   = ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Running sum, count, settle and emit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      drain_q    <= '0;
      emit_cnt_q <= '0;
    end else begin
      if (finish) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (ins_vld) begin
        sum_q   <= sum_q + SUM_W'(ins.fit);
        count_q <= count_q + 1'b1;
      end
      drain_q <= (state_q == ST_DRAIN) ? drain_q + 1'b1 : '0;
      if (finish) begin
        emit_cnt_q <= '0;
      end else if (out_load) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
      end
    end
  end

  // Product and copy test for the head entry
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(held[0].fit) * PROD_W'(count_q);
    end
    if (state_q == ST_DSTART) begin
      copy_ok_q <= (sum_q != '0) && (prod_q >= PROD_W'(sum_q));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Chain has settled and still holds an entry whenever a head is fetched
  a_head_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> (link_vld[POP_SIZE:1] == '0) && held_vld[0])
    else $error("head fetched from an unsettled or empty chain");

  // Never more results than individuals
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ORIG || state_q == ST_COPY) |-> emit_cnt_q < count_q)
    else $error("emit count overran the generation size");

  // Count stays within the chain capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POP_SIZE))
    else $error("item count beyond capacity");

endmodule

`default_nettype wire

FILE: sim/fitness_remainder_selector_top_tb.sv
// Testbench for the fitness remainder selector: random generations, self-checking picks.
`default_nettype none

module fitness_remainder_selector_top_tb;

  import frs_pkg::*;

  localparam int          RUN_LIMIT  = 400000;
  localparam int          DRAIN_WAIT = 100;
  localparam int          MAX_REPORT = 20;
  localparam int          GEN_ITEMS  = 450;
  localparam logic [63:0] Q16_ONE    = 64'd65536;
  localparam logic [63:0] EXP_SAT    = 64'd4194303;
  localparam logic [31:0] FIT_MASK   = 32'((64'd1 << FITNESS_BITS) - 64'd1);

  // Fitness styles for one generation
  typedef enum int {
    FS_WIDE,
    FS_TIES,
    FS_EXTREME,
    FS_ZERO,
    FS_MIXED
  } fit_style_e;

  logic      clk_i;
  logic      rst_ni     = 1'b0;
  logic      feed_valid = 1'b0;
  in_item_t  feed_item  = '0;
  logic      sink_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int        cycle_count    = 0;
  int        mismatch_count = 0;

  // Stimulus waiting to go out, and picks the selector must still produce
  in_item_t  fitness_q[$];
  out_item_t picks_q[$];

  // Shadow of the generation being loaded
  logic [31:0] held_fit [0:POP_SIZE-1];
  logic [36:0] fit_total  = '0;
  int          held_count = 0;

  fitness_remainder_selector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (feed_valid),
    .in_stall_o (in_stall),
    .in_item_i  (feed_item),
    .out_valid_o(out_valid),
    .out_stall_i(sink_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Q16 expectation, saturated to the field width
  function automatic logic [EXP_W-1:0] expectation_of(logic [31:0] fit, int n,
                                                      logic [36:0] total);
    logic [63:0] q;
    if (total == '0) return '0;
    q = (64'(fit) * 64'(n) * Q16_ONE) / 64'(total);
    return (q > EXP_SAT) ? EXP_SAT[EXP_W-1:0] : q[EXP_W-1:0];
  endfunction

  // Build the ranked list for the held generation and queue the first n picks
  task automatic close_generation();
    logic [31:0] c_fit  [0:2*POP_SIZE-1];
    logic [4:0]  c_idx  [0:2*POP_SIZE-1];
    logic        c_copy [0:2*POP_SIZE-1];
    logic [31:0] k_fit;
    logic [4:0]  k_idx;
    logic        k_copy;
    out_item_t   pick;
    int          n, m, j;
    n = held_count;
    m = 0;
    for (int i = 0; i < n; i++) begin
      c_fit[m] = held_fit[i];
      c_idx[m] = 5'(i);
      c_copy[m] = 1'b0;
      m++;
      if (fit_total != '0 && 64'(held_fit[i]) * 64'(n) >= 64'(fit_total)) begin
        c_fit[m] = held_fit[i];
        c_idx[m] = 5'(i);
        c_copy[m] = 1'b1;
        m++;
      end
    end
    // stable insertion, highest fitness first
    for (int i = 1; i < m; i++) begin
      k_fit = c_fit[i];
      k_idx = c_idx[i];
      k_copy = c_copy[i];
      j = i;
      while (j > 0 && c_fit[j-1] < k_fit) begin
        c_fit[j] = c_fit[j-1];
        c_idx[j] = c_idx[j-1];
        c_copy[j] = c_copy[j-1];
        j--;
      end
      c_fit[j] = k_fit;
      c_idx[j] = k_idx;
      c_copy[j] = k_copy;
    end
    for (int k = 0; k < n; k++) begin
      pick.source_index = c_idx[k];
      pick.expectation_q16 = expectation_of(c_fit[k], n, fit_total);
      pick.is_copy = c_copy[k];
      pick.last_result = (k == n - 1);
      picks_q = {picks_q, pick};
    end
    fit_total = '0;
    held_count = 0;
  endtask

  // Shadow update for one accepted item
  task automatic take_fitness(in_item_t it);
    logic [31:0] fit;
    fit = it.fitness & FIT_MASK;
    if (held_count < POP_SIZE) begin
      held_fit[held_count] = fit;
      fit_total = fit_total + 37'(fit);
      held_count++;
    end
    if (it.last_item) close_generation();
  endtask

  function automatic logic [31:0] draw_fitness(fit_style_e style);
    fit_style_e s;
    s = style;
    if (s == FS_MIXED) s = fit_style_e'($urandom_range(0, 2));
    case (s)
      FS_WIDE: begin
        // wide values, sometimes shortened to small magnitudes
        if ($urandom_range(0, 3) == 0) return $urandom >> $urandom_range(8, 31);
        return $urandom;
      end
      FS_TIES: return 32'($urandom_range(0, 3));
      FS_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  task automatic add_item(logic [31:0] fit, logic last);
    in_item_t it;
    it.fitness = fit;
    it.last_item = last;
    fitness_q = {fitness_q, it};
  endtask

  task automatic add_generation(int len, fit_style_e style);
    for (int i = 0; i < len; i++) add_item(draw_fitness(style), i == len - 1);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: one item at a time from fitness_q, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin : feed_p
    int   idle_left;
    int   calm_left;
    logic keep;
    if (!rst_ni) begin
      feed_valid <= 1'b0;
      feed_item <= '0;
      idle_left = 0;
      calm_left = 0;
    end else begin
      keep = feed_valid;
      if (feed_valid && !in_stall) begin
        take_fitness(feed_item);
        keep = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          idle_left = gap_len();
          if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 40);
        end
      end
      if (!keep) begin
        if (idle_left > 0) begin
          idle_left--;
          feed_valid <= 1'b0;
        end else if (fitness_q.size() != 0) begin
          feed_item <= fitness_q.pop_front();
          feed_valid <= 1'b1;
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted pick, alternate free and stalled stretches
  // Picks print as index/expectation/copy/last
  always @(posedge clk_i or negedge rst_ni) begin : sink_p
    int        phase_left;
    out_item_t want;
    if (!rst_ni) begin
      sink_stall <= 1'b0;
      phase_left = 0;
    end else begin
      if (out_valid && !sink_stall) begin
        if (picks_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("%0t: unexpected pick: expected none, actual %0d/%0d/%0b/%0b",
                     $time, out_item.source_index, out_item.expectation_q16,
                     out_item.is_copy, out_item.last_result);
        end else begin
          want = picks_q.pop_front();
          if (out_item !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT)
              $display("%0t: pick mismatch: expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
                       $time, want.source_index, want.expectation_q16, want.is_copy,
                       want.last_result, out_item.source_index, out_item.expectation_q16,
                       out_item.is_copy, out_item.last_result);
          end
        end
      end
      if (phase_left > 0) begin
        phase_left--;
      end else if (sink_stall || $urandom_range(0, 1) == 1) begin
        sink_stall <= 1'b0;
        phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
      end else begin
        sink_stall <= 1'b1;
        phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_p
    int total;
    int len;
    int r;
    // directed generations: lone individual, zero sums, ties, extremes
    add_item(32'hFFFF_FFFF, 1'b1);
    add_item(32'h0000_0000, 1'b1);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0000, 1'b1);
    add_item(32'd5, 1'b0);
    add_item(32'd5, 1'b0);
    add_item(32'd5, 1'b1);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b1);
    add_item(32'd1, 1'b0);
    add_item(32'd0, 1'b0);
    add_item(32'd3, 1'b0);
    add_item(32'd3, 1'b0);
    add_item(32'd0, 1'b1);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'd1, 1'b1);
    total = fitness_q.size();

    // random generations, mostly short, some longer up to full capacity and a few past it
    while (total < GEN_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 78) len = $urandom_range(1, 8);
      else if (r < 94) len = $urandom_range(9, POP_SIZE);
      else len = $urandom_range(POP_SIZE + 1, POP_SIZE + 4);
      r = $urandom_range(0, 99);
      if (r < 40) add_generation(len, FS_WIDE);
      else if (r < 65) add_generation(len, FS_TIES);
      else if (r < 80) add_generation(len, FS_EXTREME);
      else if (r < 84) add_generation(len, FS_ZERO);
      else add_generation(len, FS_MIXED);
      total += len;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (fitness_q.size() != 0 || feed_valid || picks_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
